// ===== hw/rtl/msmp_pkg.sv =====
// shared constants, operation codes and control structs of the mesh placement block
`timescale 1ns / 1ps
package msmp_pkg;

  localparam int FINE_POINTS = 4096;
  localparam int FINE_W      = $clog2(FINE_POINTS);
  localparam int IDX_W       = FINE_W + 1;
  localparam int MAX_CELLS   = 64;
  localparam int CELL_W      = $clog2(MAX_CELLS);
  localparam int CNT_W       = CELL_W + 1;
  localparam int CUM_W       = 60;
  localparam int FRAC_BITS   = 16;
  localparam int DENS_W      = 16;
  localparam int RAD_W       = 32;
  localparam int R4_W        = 2 * IDX_W;
  localparam int STEP_W      = FINE_W + 4;
  localparam int WGT_W       = DENS_W + R4_W;
  localparam int POS_W       = FINE_W + FRAC_BITS + 1;
  localparam int PROD_W      = POS_W + RAD_W;
  localparam int DIV_NUM_W   = 64;
  localparam int DIV_DEN_W   = 32;

  localparam logic [R4_W-1:0] BLEND_SQ =
    R4_W'((longint'(9) * FINE_POINTS * FINE_POINTS) / 100);
  localparam logic [CUM_W-1:0] CUM_MAX = '1;

  localparam logic [1:0] CFG_OUTER = 2'd0;
  localparam logic [1:0] CFG_INNER = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_INIT      = 5'd1;
  localparam logic [4:0] OP_DIV_II    = 5'd2;
  localparam logic [4:0] OP_RD_II     = 5'd3;
  localparam logic [4:0] OP_LD_START  = 5'd4;
  localparam logic [4:0] OP_DIV_SH    = 5'd5;
  localparam logic [4:0] OP_LD_Q      = 5'd6;
  localparam logic [4:0] OP_TGT       = 5'd7;
  localparam logic [4:0] OP_SRCH_RD   = 5'd8;
  localparam logic [4:0] OP_SRCH_CMP  = 5'd9;
  localparam logic [4:0] OP_RD_LO     = 5'd10;
  localparam logic [4:0] OP_LD_LO     = 5'd11;
  localparam logic [4:0] OP_LD_HI     = 5'd12;
  localparam logic [4:0] OP_FRAC_STEP = 5'd13;
  localparam logic [4:0] OP_MUL       = 5'd14;
  localparam logic [4:0] OP_EMIT_FACE = 5'd15;
  localparam logic [4:0] OP_EMIT_LAST = 5'd16;

  typedef struct packed {
    logic       in_acc;
    logic [4:0] op;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic last_sample;
    logic ii_needed;
    logic div_busy;
    logic srch_more;
    logic frac_busy;
    logic k_lt_n;
    logic out_last;
  } ctl_sts_t;

endpackage

// ===== hw/rtl/msmp_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module msmp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [msmp_pkg::DIV_NUM_W-1:0]    num,
  input  logic [msmp_pkg::DIV_DEN_W-1:0]    den,
  output logic                              busy,
  output logic [msmp_pkg::DIV_NUM_W-1:0]    quo,
  output logic [msmp_pkg::DIV_DEN_W-1:0]    rem
);

  localparam int CW = $clog2(msmp_pkg::DIV_NUM_W) + 1;

  logic                            busy_r;
  logic [CW-1:0]                   cnt_r;
  logic [msmp_pkg::DIV_NUM_W-1:0]  num_r;
  logic [msmp_pkg::DIV_DEN_W-1:0]  rem_r;
  logic [msmp_pkg::DIV_DEN_W-1:0]  den_r;
  logic [msmp_pkg::DIV_DEN_W:0]    rem_sh;
  logic [msmp_pkg::DIV_DEN_W:0]    rem_sub;
  logic                            ge;

  always_comb begin
    rem_sh  = {rem_r, num_r[msmp_pkg::DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(msmp_pkg::DIV_NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= {num_r[msmp_pkg::DIV_NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[msmp_pkg::DIV_DEN_W-1:0] : rem_sh[msmp_pkg::DIV_DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/msmp_dp.sv =====
// datapath: weight pipeline, cumulative store, search, interpolation and output registers
`timescale 1ns / 1ps
module msmp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msmp_pkg::ctl_cmd_t            cmd,
  output msmp_pkg::ctl_sts_t            sts,
  input  logic [msmp_pkg::DENS_W-1:0]   in_tdata,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [msmp_pkg::RAD_W-1:0]    cfg_wdata,
  output logic [135:0]                  out_tdata,
  output logic                          out_tlast
);

  localparam int CW  = msmp_pkg::CUM_W;
  localparam int RW  = msmp_pkg::RAD_W;
  localparam int IW  = msmp_pkg::IDX_W;
  localparam int FW  = msmp_pkg::FINE_W;
  localparam int NW  = msmp_pkg::CNT_W;
  localparam logic [IW-1:0] FINE_TOP = IW'(msmp_pkg::FINE_POINTS);

  // configuration
  logic [RW-1:0] cfg_outer_r, cfg_inner_r;
  logic [NW-1:0] cfg_count_r;

  // load pipeline
  logic [FW-1:0]                    cnt_r;
  logic [msmp_pkg::R4_W-1:0]        r4_r;
  logic [msmp_pkg::STEP_W-1:0]      step_r;
  logic                             s1_v_r, s2_v_r, s1_first_r, s2_first_r;
  logic [msmp_pkg::DENS_W-1:0]      s1_d_r;
  logic [msmp_pkg::R4_W-1:0]        s1_m_r;
  logic [FW-1:0]                    s1_a_r, s2_a_r;
  logic [msmp_pkg::WGT_W-1:0]       s2_w_r;
  logic [CW-1:0]                    sum_r;
  logic [CW:0]                      sum_add;
  logic [CW-1:0]                    sum_sat;

  logic [CW-1:0] cum_mem_r [msmp_pkg::FINE_POINTS];
  logic [CW-1:0] rd_data_r;
  logic          rd_zero_r;
  logic          rd_en;
  logic [IW-1:0] rd_a;
  logic [FW-1:0] rd_addr;
  logic [CW-1:0] rd_eff;

  // placement
  logic [RW-1:0] outer_r, inner_r, face_prev_r;
  logic [NW-1:0] n_r, k_r, t_r, racc_r;
  logic [CW-1:0] w_start_r, q_r, qk_r, target_r, lo_w_r, den_r;
  logic [CW:0]   num_r;
  logic [NW-1:0] rem_r;
  logic [IW-1:0] lo_r, hi_r, mid_r, mid_c, idx_c, ii_c;
  logic [msmp_pkg::FRAC_BITS:0] frac_r;
  logic [4:0]    fcnt_r;
  logic [msmp_pkg::PROD_W-1:0] prod_r;
  logic [msmp_pkg::POS_W-1:0]  pos_c;
  logic [RW-1:0] face_c, face_m;
  logic [NW:0]   racc_add;
  logic [CW-1:0] den_c;
  logic [CW:0]   num_c, num_sh;
  logic          fr_ge;
  logic [NW-1:0] cnt_clamp;

  // output registers
  logic [msmp_pkg::CELL_W-1:0] o_idx_r;
  logic [RW-1:0] o_fi_r, o_fo_r, o_ctr_r, o_wid_r;
  logic          o_last_r;
  logic [RW:0]   ctr_sum;

  // divider
  logic                              div_start, div_busy;
  logic [msmp_pkg::DIV_NUM_W-1:0]    div_num, div_quo;
  logic [msmp_pkg::DIV_DEN_W-1:0]    div_den, div_rem;
  logic [CW-1:0]                     shell_c;

  msmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_outer_r <= RW'(65536);
      cfg_inner_r <= '0;
      cfg_count_r <= NW'(msmp_pkg::MAX_CELLS);
    end else if (cfg_we) begin
      case (cfg_addr)
        msmp_pkg::CFG_OUTER: cfg_outer_r <= cfg_wdata;
        msmp_pkg::CFG_INNER: cfg_inner_r <= cfg_wdata;
        msmp_pkg::CFG_COUNT: cfg_count_r <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // weight pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      r4_r   <= msmp_pkg::R4_W'(1);
      step_r <= msmp_pkg::STEP_W'(8);
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.in_acc;
      s2_v_r <= s1_v_r;
      if (cmd.in_acc) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          r4_r   <= msmp_pkg::R4_W'(1);
          step_r <= msmp_pkg::STEP_W'(8);
        end else begin
          r4_r   <= r4_r + msmp_pkg::R4_W'(step_r);
          step_r <= step_r + msmp_pkg::STEP_W'(8);
        end
      end
    end
  end

  always_comb begin
    sum_add = {1'b0, (s2_first_r ? '0 : sum_r)} + (CW+1)'(s2_w_r);
    sum_sat = sum_add[CW] ? msmp_pkg::CUM_MAX : sum_add[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.in_acc) begin
      s1_d_r     <= in_tdata;
      s1_m_r     <= (r4_r > msmp_pkg::BLEND_SQ) ? r4_r : msmp_pkg::BLEND_SQ;
      s1_a_r     <= cnt_r;
      s1_first_r <= cnt_r == '0;
    end
    if (s1_v_r) begin
      s2_w_r     <= s1_d_r * s1_m_r;
      s2_a_r     <= s1_a_r;
      s2_first_r <= s1_first_r;
    end
    if (s2_v_r) begin
      sum_r <= sum_sat;
    end
  end

  // cumulative store, entry zero reads as zero
  always_comb begin
    ii_c = (|div_quo[msmp_pkg::DIV_NUM_W-1:IW] || div_quo[IW-1:0] > FINE_TOP) ?
           FINE_TOP : div_quo[IW-1:0];
    mid_c = lo_r + ((hi_r - lo_r) >> 1);
    if (lo_r == '0) begin
      idx_c = IW'(1);
    end else if (lo_r > FINE_TOP) begin
      idx_c = FINE_TOP;
    end else begin
      idx_c = lo_r;
    end
    rd_en = 1'b1;
    case (cmd.op)
      msmp_pkg::OP_RD_II:   rd_a = ii_c;
      msmp_pkg::OP_SRCH_RD: rd_a = mid_c;
      msmp_pkg::OP_RD_LO:   rd_a = idx_c - 1'b1;
      msmp_pkg::OP_LD_LO:   rd_a = idx_c;
      default: begin
        rd_a  = '0;
        rd_en = 1'b0;
      end
    endcase
    rd_addr = FW'(rd_a - 1'b1);
    rd_eff  = rd_zero_r ? '0 : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      cum_mem_r[s2_a_r] <= sum_sat;
    end
    if (rd_en) begin
      rd_data_r <= cum_mem_r[rd_addr];
      rd_zero_r <= rd_a == '0;
    end
  end

  // placement datapath
  always_comb begin
    cnt_clamp = (cfg_count_r == '0) ? NW'(1) :
                (cfg_count_r > NW'(msmp_pkg::MAX_CELLS)) ? NW'(msmp_pkg::MAX_CELLS) :
                cfg_count_r;
    shell_c   = sum_r - w_start_r;
    div_start = (cmd.op == msmp_pkg::OP_DIV_II) || (cmd.op == msmp_pkg::OP_DIV_SH);
    if (cmd.op == msmp_pkg::OP_DIV_SH) begin
      div_num = msmp_pkg::DIV_NUM_W'(shell_c);
      div_den = msmp_pkg::DIV_DEN_W'(n_r);
    end else begin
      div_num = msmp_pkg::DIV_NUM_W'({inner_r, {FW{1'b0}}});
      div_den = outer_r;
    end
    den_c  = rd_eff - lo_w_r;
    num_c  = (target_r > lo_w_r) ? {1'b0, target_r - lo_w_r} : '0;
    num_sh = {num_r[CW-1:0], 1'b0};
    fr_ge  = num_sh >= {1'b0, den_r};
    pos_c  = msmp_pkg::POS_W'({FW'(idx_c - 1'b1), {msmp_pkg::FRAC_BITS{1'b0}}})
             + msmp_pkg::POS_W'(frac_r);
    if (pos_c > msmp_pkg::POS_W'({FINE_TOP, {msmp_pkg::FRAC_BITS{1'b0}}})) begin
      pos_c = msmp_pkg::POS_W'({FINE_TOP, {msmp_pkg::FRAC_BITS{1'b0}}});
    end
    face_c   = prod_r[FW+msmp_pkg::FRAC_BITS +: RW];
    face_m   = (face_c < face_prev_r) ? face_prev_r : face_c;
    racc_add = {1'b0, racc_r} + {1'b0, rem_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r   <= '0;
      o_last_r <= 1'b0;
    end else begin
      case (cmd.op)
        msmp_pkg::OP_LD_HI: begin
          fcnt_r <= (den_c != '0 && num_c < {1'b0, den_c}) ? 5'd16 : 5'd0;
        end
        msmp_pkg::OP_FRAC_STEP: fcnt_r <= fcnt_r - 1'b1;
        msmp_pkg::OP_EMIT_FACE: o_last_r <= 1'b0;
        msmp_pkg::OP_EMIT_LAST: o_last_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      msmp_pkg::OP_INIT: begin
        outer_r     <= cfg_outer_r;
        inner_r     <= (cfg_inner_r > cfg_outer_r) ? cfg_outer_r : cfg_inner_r;
        face_prev_r <= (cfg_inner_r > cfg_outer_r) ? cfg_outer_r : cfg_inner_r;
        n_r         <= cnt_clamp;
        w_start_r   <= '0;
      end
      msmp_pkg::OP_LD_START: w_start_r <= rd_eff;
      msmp_pkg::OP_LD_Q: begin
        q_r    <= CW'(div_quo);
        qk_r   <= CW'(div_quo);
        rem_r  <= NW'(div_rem);
        racc_r <= NW'(div_rem);
        t_r    <= '0;
        k_r    <= NW'(1);
      end
      msmp_pkg::OP_TGT: begin
        target_r <= w_start_r + qk_r + CW'(t_r);
        lo_r     <= '0;
        hi_r     <= FINE_TOP + 1'b1;
      end
      msmp_pkg::OP_SRCH_RD: mid_r <= mid_c;
      msmp_pkg::OP_SRCH_CMP: begin
        if (rd_eff < target_r) begin
          lo_r <= mid_r + 1'b1;
        end else begin
          hi_r <= mid_r;
        end
      end
      msmp_pkg::OP_LD_LO: lo_w_r <= rd_eff;
      msmp_pkg::OP_LD_HI: begin
        den_r  <= den_c;
        num_r  <= num_c;
        frac_r <= (den_c == '0) ? '0 :
                  (num_c >= {1'b0, den_c}) ? {1'b1, {msmp_pkg::FRAC_BITS{1'b0}}} : '0;
      end
      msmp_pkg::OP_FRAC_STEP: begin
        num_r  <= fr_ge ? num_sh - {1'b0, den_r} : num_sh;
        frac_r <= {frac_r[msmp_pkg::FRAC_BITS-1:0], fr_ge};
      end
      msmp_pkg::OP_MUL: prod_r <= pos_c * outer_r;
      msmp_pkg::OP_EMIT_FACE: begin
        o_idx_r     <= msmp_pkg::CELL_W'(k_r - 1'b1);
        o_fi_r      <= face_prev_r;
        o_fo_r      <= face_m;
        o_wid_r     <= face_m - face_prev_r;
        o_ctr_r     <= ctr_sum[RW:1];
        face_prev_r <= face_m;
        k_r         <= k_r + 1'b1;
        qk_r        <= qk_r + q_r;
        if (racc_add >= {1'b0, n_r}) begin
          racc_r <= NW'(racc_add - {1'b0, n_r});
          t_r    <= t_r + 1'b1;
        end else begin
          racc_r <= NW'(racc_add);
        end
      end
      msmp_pkg::OP_EMIT_LAST: begin
        o_idx_r     <= msmp_pkg::CELL_W'(n_r - 1'b1);
        o_fi_r      <= face_prev_r;
        o_fo_r      <= outer_r;
        o_wid_r     <= outer_r - face_prev_r;
        o_ctr_r     <= ctr_sum[RW:1];
        face_prev_r <= outer_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.op == msmp_pkg::OP_EMIT_LAST) begin
      ctr_sum = {1'b0, face_prev_r} + {1'b0, outer_r};
    end else begin
      ctr_sum = {1'b0, face_prev_r} + {1'b0, face_m};
    end
  end

  always_comb begin
    sts.pipe_busy   = s1_v_r | s2_v_r;
    sts.last_sample = cnt_r == '1;
    sts.ii_needed   = (inner_r != '0) && (outer_r != '0);
    sts.div_busy    = div_busy;
    sts.srch_more   = lo_r < hi_r;
    sts.frac_busy   = fcnt_r != '0;
    sts.k_lt_n      = k_r < n_r;
    sts.out_last    = o_last_r;
  end

  assign out_tdata = {2'b00, o_wid_r, o_ctr_r, o_fo_r, o_fi_r, o_idx_r};
  assign out_tlast = o_last_r;

endmodule

// ===== hw/rtl/msmp_ctrl.sv =====
// controller state machine sequencing load, divisions, searches and output
`timescale 1ns / 1ps
module msmp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  msmp_pkg::ctl_sts_t sts,
  output msmp_pkg::ctl_cmd_t cmd
);

  localparam logic [4:0] ST_LOAD   = 5'd0;
  localparam logic [4:0] ST_DRAIN  = 5'd1;
  localparam logic [4:0] ST_INIT   = 5'd2;
  localparam logic [4:0] ST_DIVII  = 5'd3;
  localparam logic [4:0] ST_WDIVII = 5'd4;
  localparam logic [4:0] ST_RDII   = 5'd5;
  localparam logic [4:0] ST_LDST   = 5'd6;
  localparam logic [4:0] ST_DIVSH  = 5'd7;
  localparam logic [4:0] ST_WDIVSH = 5'd8;
  localparam logic [4:0] ST_LDQ    = 5'd9;
  localparam logic [4:0] ST_TGT    = 5'd10;
  localparam logic [4:0] ST_SRCH   = 5'd11;
  localparam logic [4:0] ST_SCMP   = 5'd12;
  localparam logic [4:0] ST_LDLO   = 5'd13;
  localparam logic [4:0] ST_LDHI   = 5'd14;
  localparam logic [4:0] ST_FRAC   = 5'd15;
  localparam logic [4:0] ST_FACE   = 5'd16;
  localparam logic [4:0] ST_OUT    = 5'd17;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.in_acc = 1'b0;
    cmd.op     = msmp_pkg::OP_NOP;
    case (state_r)
      ST_LOAD: begin
        cmd.in_acc = in_tvalid;
        if (in_tvalid && sts.last_sample) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.op    = msmp_pkg::OP_INIT;
        state_nxt = ST_DIVII;
      end
      ST_DIVII: begin
        if (sts.ii_needed) begin
          cmd.op    = msmp_pkg::OP_DIV_II;
          state_nxt = ST_WDIVII;
        end else begin
          state_nxt = ST_DIVSH;
        end
      end
      ST_WDIVII: begin
        if (!sts.div_busy) begin
          state_nxt = ST_RDII;
        end
      end
      ST_RDII: begin
        cmd.op    = msmp_pkg::OP_RD_II;
        state_nxt = ST_LDST;
      end
      ST_LDST: begin
        cmd.op    = msmp_pkg::OP_LD_START;
        state_nxt = ST_DIVSH;
      end
      ST_DIVSH: begin
        cmd.op    = msmp_pkg::OP_DIV_SH;
        state_nxt = ST_WDIVSH;
      end
      ST_WDIVSH: begin
        if (!sts.div_busy) begin
          state_nxt = ST_LDQ;
        end
      end
      ST_LDQ: begin
        cmd.op    = msmp_pkg::OP_LD_Q;
        state_nxt = ST_TGT;
      end
      ST_TGT: begin
        if (sts.k_lt_n) begin
          cmd.op    = msmp_pkg::OP_TGT;
          state_nxt = ST_SRCH;
        end else begin
          cmd.op    = msmp_pkg::OP_EMIT_LAST;
          state_nxt = ST_OUT;
        end
      end
      ST_SRCH: begin
        if (sts.srch_more) begin
          cmd.op    = msmp_pkg::OP_SRCH_RD;
          state_nxt = ST_SCMP;
        end else begin
          cmd.op    = msmp_pkg::OP_RD_LO;
          state_nxt = ST_LDLO;
        end
      end
      ST_SCMP: begin
        cmd.op    = msmp_pkg::OP_SRCH_CMP;
        state_nxt = ST_SRCH;
      end
      ST_LDLO: begin
        cmd.op    = msmp_pkg::OP_LD_LO;
        state_nxt = ST_LDHI;
      end
      ST_LDHI: begin
        cmd.op    = msmp_pkg::OP_LD_HI;
        state_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        if (sts.frac_busy) begin
          cmd.op = msmp_pkg::OP_FRAC_STEP;
        end else begin
          cmd.op    = msmp_pkg::OP_MUL;
          state_nxt = ST_FACE;
        end
      end
      ST_FACE: begin
        cmd.op    = msmp_pkg::OP_EMIT_FACE;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = sts.out_last ? ST_LOAD : ST_TGT;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = state_r == ST_LOAD;
  assign out_tvalid = state_r == ST_OUT;

endmodule

// ===== hw/rtl/mass_shell_mesh_placement_unit.sv =====
// top level of the mass shell radial mesh placement block
`timescale 1ns / 1ps
// takes 4096 density items at one per cycle into a 4096 x 60 bit cumulative store, then
// after the weight pipeline drains places up to 64 cells and returns one item per cell,
// innermost first. placement first finds the inner start index (the shared divider plus a
// store read) when the inner and outer radii are nonzero, then divides for the shell share,
// then handles each interior face: a 13-step lower-bound search with each step on the
// single store read port, two reads for the bracketing entries, 16 fraction bits and one
// multiply. input is held off from the last sample until the last cell item is taken.
module mass_shell_mesh_placement_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // density
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // cell_index, face_inner, face_outer, center, width
  output logic         out_tlast,  // last_cell
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  msmp_pkg::ctl_cmd_t cmd;
  msmp_pkg::ctl_sts_t sts;

  msmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  msmp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// ===== hw/rtl/msmp_chk.sv =====
// port checker for the mesh placement block and its bind
`timescale 1ns / 1ps
module msmp_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic         out_tlast
);

  // no input taken while cells are being returned
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // run ends with the final cell, then loading resumes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("no return to load after final cell");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[69:38] >= out_tdata[37:6] &&
                   out_tdata[133:102] == out_tdata[69:38] - out_tdata[37:6])
    else $error("face order or width wrong");

endmodule

bind mass_shell_mesh_placement_unit msmp_chk u_chk (.*);

// ===== bench/mass_shell_mesh_placement_unit_tb.sv =====
// testbench for the mass shell mesh placement unit: density runs checked against a cell predictor
`timescale 1ns / 1ps
module mass_shell_mesh_placement_unit_tb;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 12000;

  typedef enum int {DENS_UNIFORM, DENS_ZERO, DENS_FULL, DENS_SPARSE, DENS_BITS} dens_mode_t;

  typedef struct {
    logic [5:0]  cell_index;
    logic [31:0] face_inner;
    logic [31:0] face_outer;
    logic [31:0] center;
    logic [31:0] width;
    logic        last_cell;
  } cell_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = msmp_pkg::CFG_OUTER;
  logic [31:0]  cfg_wdata = '0;

  mass_shell_mesh_placement_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  longint unsigned cum_weight [0:msmp_pkg::FINE_POINTS];
  int unsigned     samples_taken = 0;
  logic [31:0]     outer_r = 32'd65536;
  logic [31:0]     inner_r = 32'd0;
  logic [6:0]      cell_cnt = 7'd64;
  cell_t           cells_due [$];

  int   sender_idle_pct = 0;
  int   recv_stall_pct  = 0;
  int   hold_cycles     = 0;
  logic hold_go         = 1'b0;
  int   mismatches      = 0;
  int   cycle_cnt       = 0;

  function automatic int unsigned first_not_below(longint unsigned target);
    int unsigned lo = 0;
    int unsigned hi = msmp_pkg::FINE_POINTS + 1;
    int unsigned mid;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (cum_weight[mid] < target) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [31:0] face_radius(longint unsigned target, logic [31:0] outer);
    int unsigned idx;
    longint unsigned lo_w, hi_w, num, den, frac, pos, pos_max;
    idx = first_not_below(target);
    if (idx < 1) idx = 1;
    if (idx > msmp_pkg::FINE_POINTS) idx = msmp_pkg::FINE_POINTS;
    lo_w = cum_weight[idx - 1];
    hi_w = cum_weight[idx];
    den = hi_w - lo_w;
    num = (target > lo_w) ? target - lo_w : 0;
    frac = 0;
    if (den != 0) begin
      if (num >= den) frac = 64'd1 << msmp_pkg::FRAC_BITS;
      else begin
        for (int b = 0; b < msmp_pkg::FRAC_BITS; b++) begin
          num = num << 1;
          frac = frac << 1;
          if (num >= den) begin
            num = num - den;
            frac = frac | 64'd1;
          end
        end
      end
    end
    pos_max = longint'(msmp_pkg::FINE_POINTS) << msmp_pkg::FRAC_BITS;
    pos = (longint'(idx - 1) << msmp_pkg::FRAC_BITS) + frac;
    if (pos > pos_max) pos = pos_max;
    return 32'((pos * longint'(outer)) / pos_max);
  endfunction

  function automatic void push_cell(int unsigned k, logic [31:0] a, logic [31:0] b, logic last);
    cell_t c;
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    c.cell_index = 6'(k);
    c.face_inner = a;
    c.face_outer = b;
    c.center     = s[32:1];
    c.width      = b - a;
    c.last_cell  = last;
    cells_due.push_back(c);
  endfunction

  function automatic void place_cells();
    logic [31:0] outer, inner, prev, f;
    int unsigned n;
    longint unsigned w_start, shell, q, rem, ii, target;
    outer = outer_r;
    inner = (inner_r > outer) ? outer : inner_r;
    n = cell_cnt;
    if (n < 1) n = 1;
    if (n > msmp_pkg::MAX_CELLS) n = msmp_pkg::MAX_CELLS;
    w_start = 0;
    if (inner > 0 && outer > 0) begin
      ii = (longint'(inner) * msmp_pkg::FINE_POINTS) / longint'(outer);
      if (ii > msmp_pkg::FINE_POINTS) ii = msmp_pkg::FINE_POINTS;
      w_start = cum_weight[ii];
    end
    shell = cum_weight[msmp_pkg::FINE_POINTS] - w_start;
    q = shell / n;
    rem = shell % n;
    prev = inner;
    for (int unsigned k = 1; k < n; k++) begin
      target = w_start + q * k + (rem * k) / n;
      f = face_radius(target, outer);
      if (f < prev) f = prev;
      push_cell(k - 1, prev, f, 1'b0);
      prev = f;
    end
    push_cell(n - 1, prev, outer, 1'b1);
  endfunction

  function automatic void accumulate_density(logic [15:0] d);
    int unsigned i;
    longint unsigned r2, w, s;
    i = (samples_taken >= msmp_pkg::FINE_POINTS) ? 0 : samples_taken;
    r2 = longint'(2 * i + 1) * longint'(2 * i + 1);
    if (r2 < longint'(msmp_pkg::BLEND_SQ)) r2 = longint'(msmp_pkg::BLEND_SQ);
    w = longint'(d) * r2;
    cum_weight[0] = 0;
    s = cum_weight[i] + w;
    if (s < cum_weight[i] || s > longint'(msmp_pkg::CUM_MAX)) s = longint'(msmp_pkg::CUM_MAX);
    cum_weight[i + 1] = s;
    i++;
    if (i < msmp_pkg::FINE_POINTS) samples_taken = i;
    else begin
      samples_taken = 0;
      place_cells();
    end
  endfunction

  function automatic logic [15:0] pick_density(dens_mode_t mode);
    case (mode)
      DENS_ZERO: begin
        return 16'h0000;
      end
      DENS_FULL: begin
        return 16'hFFFF;
      end
      DENS_SPARSE: begin
        return ($urandom_range(99) < 3) ? 16'($urandom) : 16'h0000;
      end
      DENS_BITS: begin
        return 16'h1 << $urandom_range(15);
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic send_density(logic [15:0] d);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    accumulate_density(d);
  endtask

  task automatic send_run(dens_mode_t mode);
    for (int i = 0; i < msmp_pkg::FINE_POINTS; i++) send_density(pick_density(mode));
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      msmp_pkg::CFG_OUTER: outer_r = data;
      msmp_pkg::CFG_INNER: inner_r = data;
      default:             cell_cnt = data[6:0];
    endcase
  endtask

  task automatic set_mesh(logic [31:0] outer, logic [31:0] inner, logic [31:0] count);
    write_reg(msmp_pkg::CFG_OUTER, outer);
    write_reg(msmp_pkg::CFG_INNER, inner);
    write_reg(msmp_pkg::CFG_COUNT, count);
  endtask

  task automatic test_reset_defaults();
    send_run(DENS_UNIFORM);
    wait_idle();
  endtask

  task automatic test_zero_density();
    set_mesh(32'd65536, 32'd1000, 32'd5);
    send_run(DENS_ZERO);
    wait_idle();
  endtask

  task automatic test_full_density_max_radius();
    set_mesh(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd64);
    send_run(DENS_FULL);
    wait_idle();
    set_mesh(32'hFFFF_FFFF, 32'h8000_0000, 32'd17);
    send_run(DENS_FULL);
    wait_idle();
  endtask

  task automatic test_count_clamp();
    set_mesh(32'd1, 32'd0, 32'd0);
    send_run(DENS_UNIFORM);
    wait_idle();
    set_mesh(32'd65536, 32'd70000, 32'd100);
    send_run(DENS_BITS);
    wait_idle();
  endtask

  task automatic test_outer_zero();
    set_mesh(32'd0, 32'd500, 32'd3);
    send_run(DENS_UNIFORM);
    wait_idle();
  endtask

  task automatic test_random_runs(int runs, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int r = 0; r < runs; r++) begin
      set_mesh($urandom, $urandom_range(3) == 0 ? 32'd0 : $urandom, $urandom_range(127));
      if ($urandom_range(1)) write_reg(msmp_pkg::CFG_INNER, outer_r >> $urandom_range(8));
      send_run(dens_mode_t'($urandom_range(4)));
      wait_idle();
    end
  endtask

  // receiver held off while a second run keeps offering items
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    set_mesh(32'd1 << 20, 32'd0, 32'd64);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 2 * msmp_pkg::FINE_POINTS; i++) send_density(pick_density(DENS_UNIFORM));
    in_tvalid <= 1'b0;
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_go) begin
      hold_cycles <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cell_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cell_index = out_tdata[5:0];
      got.face_inner = out_tdata[37:6];
      got.face_outer = out_tdata[69:38];
      got.center     = out_tdata[101:70];
      got.width      = out_tdata[133:102];
      got.last_cell  = out_tlast;
      if (cells_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cell item %0d", got.cell_index);
      end else begin
        want = cells_due.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cell mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                     want.cell_index, want.face_inner, want.face_outer, want.center,
                     want.width, want.last_cell, got.cell_index, got.face_inner,
                     got.face_outer, got.center, got.width, got.last_cell);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL mass_shell_mesh_placement_unit");
      $finish;
    end
  end

  initial begin
    foreach (cum_weight[i]) cum_weight[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_density();
    test_full_density_max_radius();
    test_count_clamp();
    test_outer_zero();
    test_random_runs(2, 0, 0);
    test_random_runs(2, 50, 0);
    test_random_runs(2, 0, 50);
    test_random_runs(2, 29, 29);
    test_output_backpressure();
    wait_idle();
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("PASS mass_shell_mesh_placement_unit");
    end else begin
      $display("FAIL mass_shell_mesh_placement_unit");
    end
    $finish;
  end

endmodule
